// ===== rtl/wctm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctm_pkg
// shared types and constants of the wall column texel mapper
// ----------------------------------------------------------------------------
package wctm_pkg;

   localparam int TEX_W_DEFAULT = 64;
   localparam int TEX_H_DEFAULT = 64;
   localparam int SCREEN_H      = 1024;
   localparam int FRAC_BITS     = 16;

   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] REG_TEXTURE_ROW_BYTES = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXEL_BITS        = 4'd1;

   localparam logic [15:0] TEXTURE_ROW_BYTES_RESET = 16'd256;
   localparam logic [5:0]  TEXEL_BITS_RESET        = 6'd32;

   // per-pixel payload carried along the divider chain
   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
      logic [15:0] height;
      logic [15:0] pos_lo;
      logic [31:0] hit_lo;
   } item_type;

endpackage

// ===== rtl/wctm_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctm_div_cell
// one restoring division step of the texture row step, with its payload
// ----------------------------------------------------------------------------
module wctm_div_cell #(
   parameter int   DIVW = 23,
   parameter logic DBIT = 1'b0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [15:0]          in_rem,
   input  logic [DIVW-1:0]      in_quot,
   input  wctm_pkg::item_type   in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [15:0]          out_rem,
   output logic [DIVW-1:0]      out_quot,
   output wctm_pkg::item_type   out_data
);

   logic                 valid_ff;
   logic [15:0]          rem_ff;
   logic [15:0]          rem_in;
   logic [DIVW-1:0]      quot_ff;
   logic [DIVW-1:0]      quot_in;
   wctm_pkg::item_type   data_ff;
   logic [16:0]          shifted;
   logic [16:0]          diff;
   logic                 qbit;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      shifted = {in_rem, DBIT};
      diff    = shifted - {1'b0, in_data.height};
      qbit    = (shifted >= {1'b0, in_data.height});
      rem_in  = qbit ? diff[15:0] : shifted[15:0];
      quot_in = {in_quot[DIVW-2:0], qbit};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_quot  = quot_ff;
   assign out_data  = data_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (rem_ff < data_ff.height))
      else $error("partial remainder not below line height");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (data_ff.height != 16'd0))
      else $error("zero line height in divider chain");

endmodule

// ===== rtl/wctm_tail.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wctm_tail
// texture column, texture row and byte offset stages with output register
// ----------------------------------------------------------------------------
module wctm_tail #(
   parameter int TEX_W = wctm_pkg::TEX_W_DEFAULT,
   parameter int TEX_H = wctm_pkg::TEX_H_DEFAULT,
   parameter int DIVW  = 23
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [DIVW-1:0]      in_step,
   input  wctm_pkg::item_type   in_data,
   input  logic [15:0]          texture_row_bytes,
   input  logic [5:0]           texel_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [11:0]          rsp_out_column,
   output logic [11:0]          rsp_out_row,
   output logic [5:0]           rsp_texel_u,
   output logic [5:0]           rsp_texel_v,
   output logic [23:0]          rsp_texel_offset
);

   localparam int UW  = $clog2(TEX_W);
   localparam int VW  = $clog2(TEX_H);
   localparam int DW  = 18;
   localparam int PW  = DW + DIVW + 1;
   localparam int BW  = UW + 6;
   localparam logic [UW-1:0]   U_MAX  = UW'(TEX_W - 1);
   localparam logic [VW-1:0]   V_MASK = VW'(TEX_H - 1);
   localparam logic [UW+32-1:0] TEX_W_C = (UW+32)'(TEX_W);
   localparam logic [DW-1:0]   HALF_SCREEN = DW'(wctm_pkg::SCREEN_H / 2);
   localparam logic [PW-1:0]   ROUND_BIAS = PW'((1 << wctm_pkg::FRAC_BITS) - 1);

   // stage 1
   logic                 t1_valid_ff;
   logic                 t1_ready;
   logic [11:0]          t1_column_ff;
   logic [11:0]          t1_row_ff;
   logic [UW-1:0]        t1_u_ff;
   logic [UW-1:0]        t1_u_in;
   logic signed [PW-1:0] t1_prod_ff;
   logic signed [PW-1:0] t1_prod_in;
   logic [31:0]          frac;
   logic [UW+32-1:0]     tx_wide;
   logic signed [DW-1:0] row_diff;

   // stage 2
   logic                 t2_valid_ff;
   logic                 t2_ready;
   logic [11:0]          t2_column_ff;
   logic [11:0]          t2_row_ff;
   logic [UW-1:0]        t2_u_ff;
   logic [VW-1:0]        t2_v_ff;
   logic [VW-1:0]        t2_v_in;
   logic [BW-1:0]        t2_ub_ff;
   logic [BW-1:0]        t2_ub_in;
   logic [PW-1:0]        rounded;

   // stage 3, output register
   logic                 t3_valid_ff;
   logic                 t3_ready;
   logic [11:0]          t3_column_ff;
   logic [11:0]          t3_row_ff;
   logic [5:0]           t3_u_ff;
   logic [5:0]           t3_v_ff;
   logic [23:0]          t3_offset_ff;
   logic [23:0]          t3_offset_in;
   logic [VW+16-1:0]     row_part;

   assign t3_ready = !t3_valid_ff || !rsp_stall;
   assign t2_ready = !t2_valid_ff || t3_ready;
   assign t1_ready = !t1_valid_ff || t2_ready;
   assign in_ready = t1_ready;

   always_comb begin
      frac       = {in_data.pos_lo, 16'd0} + in_data.hit_lo;
      tx_wide    = {{UW{1'b0}}, frac} * TEX_W_C;
      t1_u_in    = U_MAX - tx_wide[32 +: UW];
      row_diff   = $signed({{(DW-12){1'b0}}, in_data.row}) - $signed(HALF_SCREEN)
                 + $signed({{(DW-15){1'b0}}, in_data.height[15:1]});
      t1_prod_in = row_diff * $signed({1'b0, in_step});
   end

   always_comb begin
      rounded  = t1_prod_ff[PW-1] ? (t1_prod_ff + ROUND_BIAS) : t1_prod_ff;
      t2_v_in  = rounded[wctm_pkg::FRAC_BITS +: VW] & V_MASK;
      t2_ub_in = BW'(t1_u_ff) * BW'(texel_bits);
   end

   always_comb begin
      row_part     = (VW+16)'(t2_v_ff) * (VW+16)'(texture_row_bytes);
      t3_offset_in = 24'(row_part) + 24'(t2_ub_ff >> 3);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
      end else begin
         if (t1_ready) begin
            t1_valid_ff <= in_valid;
         end
         if (t2_ready) begin
            t2_valid_ff <= t1_valid_ff;
         end
         if (t3_ready) begin
            t3_valid_ff <= t2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (t1_ready && in_valid) begin
         t1_column_ff <= in_data.column;
         t1_row_ff    <= in_data.row;
         t1_u_ff      <= t1_u_in;
         t1_prod_ff   <= t1_prod_in;
      end
      if (t2_ready && t1_valid_ff) begin
         t2_column_ff <= t1_column_ff;
         t2_row_ff    <= t1_row_ff;
         t2_u_ff      <= t1_u_ff;
         t2_v_ff      <= t2_v_in;
         t2_ub_ff     <= t2_ub_in;
      end
      if (t3_ready && t2_valid_ff) begin
         t3_column_ff <= t2_column_ff;
         t3_row_ff    <= t2_row_ff;
         t3_u_ff      <= 6'(t2_u_ff);
         t3_v_ff      <= 6'(t2_v_ff);
         t3_offset_ff <= t3_offset_in;
      end
   end

   assign rsp_valid        = t3_valid_ff;
   assign rsp_out_column   = t3_column_ff;
   assign rsp_out_row      = t3_row_ff;
   assign rsp_texel_u      = t3_u_ff;
   assign rsp_texel_v      = t3_v_ff;
   assign rsp_texel_offset = t3_offset_ff;

   a_t1_hold: assert property (@(posedge clock) disable iff (reset)
      t1_valid_ff && !t2_ready |=> t1_valid_ff && $stable(t1_prod_ff))
      else $error("stage 1 transaction lost while held");

   a_t2_hold: assert property (@(posedge clock) disable iff (reset)
      t2_valid_ff && !t3_ready |=> t2_valid_ff && $stable(t2_v_ff))
      else $error("stage 2 transaction lost while held");

endmodule

// ===== rtl/wall_column_texel_mapper.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texel_mapper
// maps a raycast wall pixel to its texture column, row and texel byte offset
// ----------------------------------------------------------------------------
// from request to response: one entry stage, one divider cell per bit of
//   TEX_H * 65536, three tail stages
// throughput: one transaction per cycle while rsp_stall is low; the divider chain holds one pixel per cell
// rows outside the span are dropped at the entry stage and give no response
// reset clears every valid bit and loads row bytes 256 and texel bits 32
// ----------------------------------------------------------------------------
module wall_column_texel_mapper #(
   parameter int TEX_W = wctm_pkg::TEX_W_DEFAULT,
   parameter int TEX_H = wctm_pkg::TEX_H_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [11:0]                         req_screen_column,
   input  logic [11:0]                         req_screen_row,
   input  logic                                req_hit_side,
   input  logic [23:0]                         req_pos_x,
   input  logic [23:0]                         req_pos_y,
   input  logic [23:0]                         req_wall_dist,
   input  logic signed [20:0]                  req_ray_dir_x,
   input  logic signed [20:0]                  req_ray_dir_y,
   input  logic [15:0]                         req_wall_height,
   input  logic [11:0]                         req_span_start,
   input  logic [12:0]                         req_span_end,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [wctm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [wctm_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [11:0]                         rsp_out_column,
   output logic [11:0]                         rsp_out_row,
   output logic [5:0]                          rsp_texel_u,
   output logic [5:0]                          rsp_texel_v,
   output logic [23:0]                         rsp_texel_offset
);

   localparam int DIVW = $clog2(TEX_H + 1) + wctm_pkg::FRAC_BITS;
   localparam logic [DIVW-1:0] DIVIDEND = DIVW'(TEX_H) << wctm_pkg::FRAC_BITS;

   logic [15:0]          texture_row_bytes_ff;
   logic [5:0]           texel_bits_ff;

   logic                 entry_valid_ff;
   logic                 entry_ready;
   wctm_pkg::item_type   entry_data_ff;
   wctm_pkg::item_type   entry_data_in;
   logic                 in_span;
   logic signed [20:0]   dir_sel;
   logic signed [45:0]   hit_prod;

   logic                 chain_valid [0:DIVW];
   logic                 chain_ready [0:DIVW];
   logic [15:0]          chain_rem   [0:DIVW];
   logic [DIVW-1:0]      chain_quot  [0:DIVW];
   wctm_pkg::item_type   chain_data  [0:DIVW];

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         texture_row_bytes_ff <= wctm_pkg::TEXTURE_ROW_BYTES_RESET;
         texel_bits_ff        <= wctm_pkg::TEXEL_BITS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            wctm_pkg::REG_TEXTURE_ROW_BYTES: begin
               texture_row_bytes_ff <= csr_data[15:0];
            end
            wctm_pkg::REG_TEXEL_BITS: begin
               texel_bits_ff <= csr_data[5:0];
            end
            default: begin
            end
         endcase
      end
   end

   // entry stage: span check and hit point product
   always_comb begin
      in_span  = ({1'b0, req_screen_row} >= {1'b0, req_span_start})
              && ({1'b0, req_screen_row} < req_span_end);
      dir_sel  = req_hit_side ? req_ray_dir_x : req_ray_dir_y;
      hit_prod = $signed({1'b0, req_wall_dist}) * dir_sel;
      entry_data_in.column = req_screen_column;
      entry_data_in.row    = req_screen_row;
      entry_data_in.height = (req_wall_height == 16'd0) ? 16'd1 : req_wall_height;
      entry_data_in.pos_lo = req_hit_side ? req_pos_x[15:0] : req_pos_y[15:0];
      entry_data_in.hit_lo = hit_prod[31:0];
   end

   assign entry_ready = !entry_valid_ff || chain_ready[0];
   assign req_stall   = !entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (entry_ready) begin
         entry_valid_ff <= req_valid && in_span;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_ready && req_valid && in_span) begin
         entry_data_ff <= entry_data_in;
      end
   end

   assign chain_valid[0] = entry_valid_ff;
   assign chain_rem[0]   = 16'd0;
   assign chain_quot[0]  = '0;
   assign chain_data[0]  = entry_data_ff;

   // divider chain, most significant quotient bit first
   for (genvar k = 0; k < DIVW; k++) begin : g_cell
      wctm_div_cell #(
         .DIVW (DIVW),
         .DBIT (DIVIDEND[DIVW-1-k])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_rem    (chain_rem[k]),
         .in_quot   (chain_quot[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_rem   (chain_rem[k+1]),
         .out_quot  (chain_quot[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   wctm_tail #(
      .TEX_W (TEX_W),
      .TEX_H (TEX_H),
      .DIVW  (DIVW)
   ) u_tail (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (chain_valid[DIVW]),
      .in_ready          (chain_ready[DIVW]),
      .in_step           (chain_quot[DIVW]),
      .in_data           (chain_data[DIVW]),
      .texture_row_bytes (texture_row_bytes_ff),
      .texel_bits        (texel_bits_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_row       (rsp_out_row),
      .rsp_texel_u       (rsp_texel_u),
      .rsp_texel_v       (rsp_texel_v),
      .rsp_texel_offset  (rsp_texel_offset)
   );

   a_out_of_span_dropped: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !in_span |=> !entry_valid_ff)
      else $error("pixel outside span entered the pipeline");

   a_entry_height_nonzero: assert property (@(posedge clock) disable iff (reset)
      entry_valid_ff |-> (entry_data_ff.height != 16'd0))
      else $error("zero line height left the entry stage");

endmodule

// ===== tb/sv/wall_column_texel_mapper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wall_column_texel_mapper_tb
// self-checking bench: feeds wall pixels with random gaps and stalls on both
// sides, works out each texel column, row and byte offset on its own, and
// compares every response in order against the pixels that lie in their span
// ----------------------------------------------------------------------------
module wall_column_texel_mapper_tb;

   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 400;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
      logic        side;
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [23:0] wall_dist;
      logic [20:0] dir_x;
      logic [20:0] dir_y;
      logic [15:0] height;
      logic [11:0] span_start;
      logic [12:0] span_end;
   } wall_pixel_type;

   typedef struct packed {
      logic [11:0] column;
      logic [11:0] row;
      logic [5:0]  u;
      logic [5:0]  v;
      logic [23:0] offset;
   } texel_result_type;

   logic                             clock;
   logic                             reset             = 1'b1;
   logic                             req_valid         = 1'b0;
   logic                             req_stall;
   logic [11:0]                      req_screen_column = '0;
   logic [11:0]                      req_screen_row    = '0;
   logic                             req_hit_side      = 1'b0;
   logic [23:0]                      req_pos_x         = '0;
   logic [23:0]                      req_pos_y         = '0;
   logic [23:0]                      req_wall_dist     = '0;
   logic signed [20:0]               req_ray_dir_x     = '0;
   logic signed [20:0]               req_ray_dir_y     = '0;
   logic [15:0]                      req_wall_height   = '0;
   logic [11:0]                      req_span_start    = '0;
   logic [12:0]                      req_span_end      = '0;
   logic                             csr_valid         = 1'b0;
   logic                             csr_ready;
   logic [wctm_pkg::CSR_INDEX_W-1:0] csr_index         = '0;
   logic [wctm_pkg::CSR_DATA_W-1:0]  csr_data          = '0;
   logic                             rsp_valid;
   logic                             rsp_stall         = 1'b0;
   logic [11:0]                      rsp_out_column;
   logic [11:0]                      rsp_out_row;
   logic [5:0]                       rsp_texel_u;
   logic [5:0]                       rsp_texel_v;
   logic [23:0]                      rsp_texel_offset;

   texel_result_type pending_texels[$];
   logic [15:0]   row_bytes_cfg  = wctm_pkg::TEXTURE_ROW_BYTES_RESET;
   logic [5:0]    texel_bits_cfg = wctm_pkg::TEXEL_BITS_RESET;
   int            mismatch_count = 0;
   int            send_idle_pct  = 29;
   int            recv_idle_pct  = 46;
   bit            hold_request   = 1'b0;
   int            hold_left      = 0;

   wall_column_texel_mapper uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_screen_column (req_screen_column),
      .req_screen_row    (req_screen_row),
      .req_hit_side      (req_hit_side),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_wall_dist     (req_wall_dist),
      .req_ray_dir_x     (req_ray_dir_x),
      .req_ray_dir_y     (req_ray_dir_y),
      .req_wall_height   (req_wall_height),
      .req_span_start    (req_span_start),
      .req_span_end      (req_span_end),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_column    (rsp_out_column),
      .rsp_out_row       (rsp_out_row),
      .rsp_texel_u       (rsp_texel_u),
      .rsp_texel_v       (rsp_texel_v),
      .rsp_texel_offset  (rsp_texel_offset)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic bit map_texel(input wall_pixel_type p, output texel_result_type r);
      logic signed [63:0] base, dir, dist_s, hit, row_s, half_s, step_s, diff, prod, whole;
      logic [63:0]        lh, tx, u, v, off;
      r = '0;
      if (p.row < p.span_start || {1'b0, p.row} >= p.span_end)
         return 1'b0;
      lh = (p.height == 16'd0) ? 64'd1 : {48'd0, p.height};
      dist_s = {40'd0, p.wall_dist};
      if (p.side == 1'b0) begin
         base = {24'd0, p.pos_y, 16'd0};
         dir  = {{43{p.dir_y[20]}}, p.dir_y};
      end else begin
         base = {24'd0, p.pos_x, 16'd0};
         dir  = {{43{p.dir_x[20]}}, p.dir_x};
      end
      hit = base + dist_s * dir;
      tx  = ({32'd0, hit[31:0]} * 64'(wctm_pkg::TEX_W_DEFAULT)) >> 32;
      u   = 64'(wctm_pkg::TEX_W_DEFAULT) - tx - 64'd1;
      step_s = (64'(wctm_pkg::TEX_H_DEFAULT) << wctm_pkg::FRAC_BITS) / lh;
      row_s  = {52'd0, p.row};
      half_s = lh >> 1;
      diff   = row_s - 64'(wctm_pkg::SCREEN_H / 2) + half_s;
      prod   = diff * step_s;
      whole  = prod / 64'sd65536;
      v      = whole & 64'(wctm_pkg::TEX_H_DEFAULT - 1);
      off    = v * {48'd0, row_bytes_cfg} + (u * {58'd0, texel_bits_cfg}) / 64'd8;
      r.column = p.column;
      r.row    = p.row;
      r.u      = u[5:0];
      r.v      = v[5:0];
      r.offset = off[23:0];
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input texel_result_type want,
                                  input texel_result_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%s: expected col %0d row %0d u %0d v %0d offset %0d, ",
                   "got col %0d row %0d u %0d v %0d offset %0d"},
                  what, want.column, want.row, want.u, want.v, want.offset,
                  got.column, got.row, got.u, got.v, got.offset);
   endtask

   always @(posedge clock) begin : response_check
      texel_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_out_column, rsp_out_row, rsp_texel_u, rsp_texel_v, rsp_texel_offset};
         if (pending_texels.size() == 0) begin
            report_mismatch("response with nothing pending", '0, got);
         end else begin
            want = pending_texels.pop_front();
            if (got.column !== want.column || got.row !== want.row || got.u !== want.u ||
                got.v !== want.v || got.offset !== want.offset)
               report_mismatch("texel mismatch", want, got);
         end
      end
   end

   // receiver stall, with a long hold-off on request
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_request) begin
         hold_request = 1'b0;
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   task automatic send_pixel(input wall_pixel_type p);
      texel_result_type r;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_screen_column <= p.column;
      req_screen_row    <= p.row;
      req_hit_side      <= p.side;
      req_pos_x         <= p.pos_x;
      req_pos_y         <= p.pos_y;
      req_wall_dist     <= p.wall_dist;
      req_ray_dir_x     <= p.dir_x;
      req_ray_dir_y     <= p.dir_y;
      req_wall_height   <= p.height;
      req_span_start    <= p.span_start;
      req_span_end      <= p.span_end;
      req_valid         <= 1'b1;
      do @(posedge clock); while (req_stall);
      if (map_texel(p, r))
         pending_texels.push_back(r);
   endtask

   task automatic wait_for_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_texels.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_registers(input logic [15:0] row_bytes, input logic [5:0] bits);
      csr_index <= wctm_pkg::REG_TEXTURE_ROW_BYTES;
      csr_data  <= row_bytes;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      row_bytes_cfg = row_bytes;
      csr_index <= wctm_pkg::REG_TEXEL_BITS;
      csr_data  <= {10'd0, bits};
      do @(posedge clock); while (!csr_ready);
      texel_bits_cfg = bits;
      csr_valid <= 1'b0;
   endtask

   function automatic wall_pixel_type make_pixel(
      input int column, input int row, input bit side, input logic [23:0] px,
      input logic [23:0] py, input logic [23:0] wall_dist, input logic [20:0] dx,
      input logic [20:0] dy, input int height, input int s0, input int s1);
      wall_pixel_type p;
      p.column     = 12'(column);
      p.row        = 12'(row);
      p.side       = side;
      p.pos_x      = px;
      p.pos_y      = py;
      p.wall_dist  = wall_dist;
      p.dir_x      = dx;
      p.dir_y      = dy;
      p.height     = 16'(height);
      p.span_start = 12'(s0);
      p.span_end   = 13'(s1);
      return p;
   endfunction

   function automatic wall_pixel_type random_pixel();
      wall_pixel_type p;
      int          pick, s0, s1;
      p.column = 12'($urandom_range(0, 4095));
      p.side   = 1'($urandom_range(0, 1));
      p.pos_x  = 24'($urandom);
      p.pos_y  = 24'($urandom);
      p.wall_dist = $urandom_range(0, 1) ? 24'($urandom_range(0, 24'h03FFFF))
                                         : 24'($urandom);
      p.dir_x  = 21'($urandom);
      p.dir_y  = 21'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         p.height = 16'($urandom_range(0, 1));
      else if (pick <= 6)
         p.height = 16'($urandom_range(1, 2048));
      else if (pick <= 8)
         p.height = 16'($urandom);
      else
         p.height = 16'hFFFF;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         s0 = $urandom_range(0, 4095);
         s1 = $urandom_range(0, s0);
      end else if (pick == 1) begin
         s0 = $urandom_range(0, 4095);
         s1 = 4096;
      end else begin
         s0 = $urandom_range(0, 4095);
         s1 = $urandom_range(s0 + 1, 4096);
      end
      if (s1 > s0 && $urandom_range(0, 99) < 85)
         p.row = 12'($urandom_range(s0, s1 - 1));
      else
         p.row = 12'($urandom_range(0, 4095));
      p.span_start = 12'(s0);
      p.span_end   = 13'(s1);
      return p;
   endfunction

   task automatic test_directed_pixels();
      send_pixel(make_pixel(0, 0, 0, 24'h0, 24'h0, 24'h0, 21'h0, 21'h0, 0, 0, 1));
      send_pixel(make_pixel(0, 0, 1, 24'h0, 24'h0, 24'h0, 21'h0, 21'h0, 0, 0, 1));
      // zero height behaves as one
      send_pixel(make_pixel(7, 512, 0, 24'h012345, 24'h0ABCDE, 24'h018000,
                            21'h008000, 21'h1F0000, 0, 0, 4096));
      send_pixel(make_pixel(7, 512, 1, 24'h012345, 24'h0ABCDE, 24'h018000,
                            21'h008000, 21'h1F0000, 1, 0, 4096));
      send_pixel(make_pixel(8, 0, 0, 24'h030000, 24'h020000, 24'h010000,
                            21'h010000, 21'h010000, 65535, 0, 4096));
      send_pixel(make_pixel(4095, 4095, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            21'h0FFFFF, 21'h0FFFFF, 65535, 4095, 4096));
      send_pixel(make_pixel(4095, 4095, 1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            21'h0FFFFF, 21'h0FFFFF, 65535, 4095, 4096));
      // most negative ray directions give a negative hit point
      send_pixel(make_pixel(100, 300, 0, 24'h0, 24'h0, 24'hFFFFFF,
                            21'h100000, 21'h100000, 400, 0, 4096));
      send_pixel(make_pixel(100, 300, 1, 24'h0, 24'h0, 24'hFFFFFF,
                            21'h100000, 21'h100000, 400, 0, 4096));
      // row far above the wall top wraps the texture row
      send_pixel(make_pixel(1, 0, 0, 24'h0, 24'h0, 24'h0, 21'h0, 21'h0, 2, 0, 1));
      // rows outside the span, empty and inverted spans
      send_pixel(make_pixel(2, 10, 0, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 11, 20));
      send_pixel(make_pixel(2, 20, 0, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 11, 20));
      send_pixel(make_pixel(2, 100, 1, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 100, 100));
      send_pixel(make_pixel(2, 150, 1, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 200, 100));
      send_pixel(make_pixel(3, 11, 0, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 11, 20));
      send_pixel(make_pixel(3, 19, 1, 24'h1, 24'h1, 24'h1, 21'h1, 21'h1, 40, 11, 20));
      // whole-number and nearly whole hit points
      send_pixel(make_pixel(5, 600, 1, 24'h050000, 24'h0, 24'h0, 21'h0, 21'h0, 300, 0, 4096));
      send_pixel(make_pixel(5, 600, 1, 24'h05FFFF, 24'h0, 24'h0, 21'h0, 21'h0, 300, 0, 4096));
      send_pixel(make_pixel(6, 700, 0, 24'h0, 24'hAAAAAA, 24'h555555,
                            21'h155555, 21'h0AAAAA, 21845, 512, 2048));
   endtask

   task automatic test_register_settings();
      logic [15:0] row_bytes[4] = '{16'd0, 16'd65535, 16'd1, 16'd4096};
      logic [5:0]  bits[4]      = '{6'd8, 6'd32, 6'd24, 6'd16};
      for (int i = 0; i < 4; i++) begin
         wait_for_idle();
         write_registers(row_bytes[i], bits[i]);
         repeat (90) send_pixel(random_pixel());
      end
      wait_for_idle();
   endtask

   task automatic test_random_pixels(input int count, input int sender_pct,
                                     input int receiver_pct);
      wait_for_idle();
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      write_registers(16'($urandom), 6'($urandom_range(8, 32)));
      repeat (count) send_pixel(random_pixel());
      wait_for_idle();
   endtask

   task automatic test_output_backpressure();
      wait_for_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_registers(16'($urandom), 6'($urandom_range(8, 32)));
      hold_request = 1'b1;
      repeat (250) send_pixel(random_pixel());
      wait_for_idle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_pixels();
      test_register_settings();
      test_random_pixels(460, 46, 29);
      test_random_pixels(460, 0, 0);
      test_output_backpressure();
      if (mismatch_count == 0 && pending_texels.size() == 0)
         $display("wall_column_texel_mapper_tb: PASS");
      else
         $display("wall_column_texel_mapper_tb: FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("wall_column_texel_mapper_tb: FAIL");
      $finish;
   end

endmodule
